@@ hw/rtl/wsmv_pkg.sv @@
package wsmv_pkg;

    localparam int SLOTS        = 3;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int SCORE_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W        = 16 + CNT_W;
    localparam int ACC_W        = SUM_W + 2;
    localparam int CW           = ACC_W + 18;
    localparam int ZW           = 34;
    localparam int ITER_W       = 5;
    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = SUM_W;
    localparam int TURN         = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER      = 9000;
    localparam int ANGLE_BIAS   = 144000;
    localparam int CORDIC_X0    = 39797;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_SINGLE   = 2'd1,
        STATUS_MAJORITY = 2'd2,
        STATUS_MEAN     = 2'd3
    } status_t;

    localparam logic [1:0] CFG_MAX_AGE     = 2'd0;
    localparam logic [1:0] CFG_ANGLE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SPEED_LIMIT = 2'd2;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              vec_mode;
        logic [ITER_W-1:0] iter;
    } cordic_ctrl_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = 34'sd294912000;
            5'd1:    v = 34'sd174096719;
            5'd2:    v = 34'sd91987925;
            5'd3:    v = 34'sd46694507;
            5'd4:    v = 34'sd23437865;
            5'd5:    v = 34'sd11730358;
            5'd6:    v = 34'sd5866610;
            5'd7:    v = 34'sd2933484;
            5'd8:    v = 34'sd1466764;
            5'd9:    v = 34'sd733385;
            5'd10:   v = 34'sd366693;
            5'd11:   v = 34'sd183346;
            5'd12:   v = 34'sd91673;
            5'd13:   v = 34'sd45837;
            5'd14:   v = 34'sd22918;
            5'd15:   v = 34'sd11459;
            5'd16:   v = 34'sd5730;
            5'd17:   v = 34'sd2865;
            5'd18:   v = 34'sd1432;
            5'd19:   v = 34'sd716;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/wind_sample_majority_voter_unit.sv @@
// wind sample majority voter
// in channel (in_valid/in_ready): operation, sample_angle, sample_speed, now_ms.
//   operation 0 pushes a sample into the next ring slot and gives no result item;
//   operation 1 evaluates the fresh slots and gives one result item.
// out channel (out_valid/out_ready): fusion_status, fused_angle, fused_speed,
//   held in an output register until taken.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//   index 0 max age, 1 angle limit, 2 speed limit, other indexes ignored.
// one item at a time on a shared cordic step unit and compare/subtract
//   sequencer. a push reduces the angle (one subtract a cycle), then writes its slot.
//   an evaluate scans the slots and finishes directly for no or one fresh sample;
//   else it takes the majority vote, and if no pair agrees, the mean path (per slot:
//   quadrant reduction plus 20 cordic steps, then 20 vectoring steps and an 18 step divide).
// in_ready is high only while the sequencer is idle; a new item may enter while
// the previous result still waits in the output register. if the receiver stalls,
// a finished evaluate waits until the output register frees.
// reset: slots invalid, write pointer 0, registers 5000 / 3000 / 800, no result.
module wind_sample_majority_voter_unit
    import wsmv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [17:0] sample_angle,
    input  logic        [15:0] sample_speed,
    input  logic        [31:0] now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  fusion_status,
    output logic        [15:0] fused_angle,
    output logic        [15:0] fused_speed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_PNORM   = 18'b000000000000000010,
        S_SCAN    = 18'b000000000000000100,
        S_CLASS   = 18'b000000000000001000,
        S_LOADA   = 18'b000000000000010000,
        S_CMP     = 18'b000000000000100000,
        S_SCORE   = 18'b000000000001000000,
        S_PICK    = 18'b000000000010000000,
        S_MLOAD   = 18'b000000000100000000,
        S_QUAD    = 18'b000000001000000000,
        S_ROT     = 18'b000000010000000000,
        S_ACC     = 18'b000000100000000000,
        S_VLOAD   = 18'b000001000000000000,
        S_VEC     = 18'b000010000000000000,
        S_VEND    = 18'b000100000000000000,
        S_DIVINIT = 18'b001000000000000000,
        S_DIV     = 18'b010000000000000000,
        S_DONE    = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] max_age_reg, max_age_next;
    logic [14:0] angle_lim_reg, angle_lim_next;
    logic [15:0] speed_lim_reg, speed_lim_next;

    logic [15:0] slot_angle_reg [SLOTS];
    logic [15:0] slot_speed_reg [SLOTS];
    logic [31:0] slot_time_reg  [SLOTS];
    logic [SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0] write_slot_reg, write_slot_next;
    logic             slot_we;

    logic [18:0]        pn_reg, pn_next;
    logic [15:0]        pspeed_reg, pspeed_next;
    logic [31:0]        now_reg, now_next;
    logic [IDX_W-1:0]   idx_reg, idx_next, j_reg, j_next, sel_reg, sel_next;
    logic [IDX_W-1:0]   best_reg, best_next, rd_idx;
    logic [SLOTS-1:0]   fresh_reg, fresh_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SCORE_W-1:0] score_reg, score_next, best_score_reg, best_score_next;
    logic [15:0]        a_ang_reg, a_ang_next, a_spd_reg, a_spd_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [15:0]        f_reg, f_next;
    logic [1:0]         q_reg, q_next;
    logic signed [ACC_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [15:0]        res_angle_reg, res_angle_next, res_speed_reg, res_speed_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [15:0] out_angle_reg, out_angle_next, out_speed_reg, out_speed_next;

    cordic_ctrl_t         cctrl;
    logic signed [CW-1:0] cx_init, cy_init, cx, cy;
    logic signed [ZW-1:0] cz_init, cz;

    logic        in_fire, last_idx, last_j, agree;
    logic [31:0] age;
    logic [15:0] rd_ang, rd_spd, ad, sd, circ;
    logic signed [ACC_W-1:0] ux, uy;
    logic signed [CW-1:0]    xs, ys;
    logic signed [ZW-1:0]    zr;
    logic signed [ZW-17:0]   cd;
    logic [CNT_W:0]          rem_sh;

    wsmv_cordic u_cordic (
        .clk    (clk),
        .ctrl   (cctrl),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .x      (cx),
        .y      (cy),
        .z      (cz)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (state_reg == S_CMP)
            rd_idx = j_reg;
        else if (state_reg == S_CLASS)
            rd_idx = sel_reg;
        else if (state_reg == S_PICK)
            rd_idx = best_reg;
        else
            rd_idx = idx_reg;
    end

    // slot read and age, agreement of held slot against the slot being read, quadrant unfold and divide shift
    always_comb
    begin
        rd_ang   = slot_angle_reg[rd_idx];
        rd_spd   = slot_speed_reg[rd_idx];
        age      = now_reg - slot_time_reg[rd_idx];
        last_idx = (idx_reg == IDX_W'(SLOTS - 1));
        last_j   = (j_reg == IDX_W'(SLOTS - 1));
        ad       = (a_ang_reg >= rd_ang) ? a_ang_reg - rd_ang : rd_ang - a_ang_reg;
        sd       = (a_spd_reg >= rd_spd) ? a_spd_reg - rd_spd : rd_spd - a_spd_reg;
        circ     = (ad > 16'(HALF_TURN)) ? 16'(TURN) - ad : ad;
        agree    = (circ < {1'b0, angle_lim_reg}) && (sd < speed_lim_reg);
        unique case (q_reg)
            2'd0:
            begin
                ux = ACC_W'(cx);
                uy = ACC_W'(cy);
            end
            2'd1:
            begin
                ux = -ACC_W'(cy);
                uy = ACC_W'(cx);
            end
            2'd2:
            begin
                ux = -ACC_W'(cx);
                uy = -ACC_W'(cy);
            end
            default:
            begin
                ux = ACC_W'(cy);
                uy = -ACC_W'(cx);
            end
        endcase
        xs     = CW'(sx_reg) <<< 16;
        ys     = CW'(sy_reg) <<< 16;
        zr     = cz + ZW'(32768);
        cd     = zr[ZW-1:16];
        rem_sh = {rem_reg, sum_reg[SUM_W-1]};
    end

    always_comb
    begin
        state_next      = state_reg;
        max_age_next    = max_age_reg;
        angle_lim_next  = angle_lim_reg;
        speed_lim_next  = speed_lim_reg;
        slot_valid_next = slot_valid_reg;
        write_slot_next = write_slot_reg;
        slot_we         = 1'b0;
        pn_next         = pn_reg;
        pspeed_next     = pspeed_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        sel_next        = sel_reg;
        best_next       = best_reg;
        fresh_next      = fresh_reg;
        n_next          = n_reg;
        score_next      = score_reg;
        best_score_next = best_score_reg;
        a_ang_next      = a_ang_reg;
        a_spd_next      = a_spd_reg;
        sum_next        = sum_reg;
        f_next          = f_reg;
        q_next          = q_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        iter_next       = iter_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_angle_next  = res_angle_reg;
        res_speed_next  = res_speed_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_angle_next  = out_angle_reg;
        out_speed_next  = out_speed_reg;
        cctrl           = '0;
        cctrl.iter      = iter_reg;
        cx_init         = CW'(CORDIC_X0);
        cy_init         = '0;
        cz_init         = ZW'(f_reg) <<< 16;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_AGE)
                max_age_next = cfg_data;
            if (cfg_index == CFG_ANGLE_LIMIT)
                angle_lim_next = cfg_data[14:0];
            if (cfg_index == CFG_SPEED_LIMIT)
                speed_lim_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    now_next = now_ms;
                    if (!operation)
                    begin
                        pn_next     = 19'({sample_angle[17], sample_angle}) + 19'(ANGLE_BIAS);
                        pspeed_next = sample_speed;
                        state_next  = S_PNORM;
                    end
                    else
                    begin
                        idx_next   = '0;
                        fresh_next = '0;
                        n_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_PNORM:
            begin
                if (pn_reg >= 19'(TURN))
                    pn_next = pn_reg - 19'(TURN);
                else
                begin
                    slot_we = 1'b1;
                    slot_valid_next[write_slot_reg] = 1'b1;
                    write_slot_next = (write_slot_reg == IDX_W'(SLOTS - 1)) ? '0
                                      : write_slot_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (slot_valid_reg[idx_reg] && (age <= {16'b0, max_age_reg}))
                begin
                    fresh_next[idx_reg] = 1'b1;
                    n_next   = n_reg + 1'b1;
                    sel_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                    state_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (n_reg == '0)
                begin
                    res_status_next = STATUS_NONE;
                    res_angle_next  = '0;
                    res_speed_next  = '0;
                    state_next      = S_DONE;
                end
                else if (n_reg == CNT_W'(1))
                begin
                    res_status_next = STATUS_SINGLE;
                    res_angle_next  = rd_ang;
                    res_speed_next  = rd_spd;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next        = '0;
                    best_score_next = '0;
                    best_next       = '0;
                    state_next      = S_LOADA;
                end
            end
            S_LOADA:
            begin
                if (fresh_reg[idx_reg])
                begin
                    a_ang_next = rd_ang;
                    a_spd_next = rd_spd;
                    j_next     = '0;
                    score_next = '0;
                    state_next = S_CMP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (last_idx)
                        state_next = S_PICK;
                end
            end
            S_CMP:
            begin
                if (fresh_reg[j_reg] && (j_reg != idx_reg) && agree)
                    score_next = score_reg + 1'b1;
                j_next = j_reg + 1'b1;
                if (last_j)
                    state_next = S_SCORE;
            end
            S_SCORE:
            begin
                if (score_reg > best_score_reg)
                begin
                    best_score_next = score_reg;
                    best_next       = idx_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? S_PICK : S_LOADA;
            end
            S_PICK:
            begin
                if (best_score_reg != '0)
                begin
                    res_status_next = STATUS_MAJORITY;
                    res_angle_next  = rd_ang;
                    res_speed_next  = rd_spd;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    sx_next    = '0;
                    sy_next    = '0;
                    state_next = S_MLOAD;
                end
            end
            S_MLOAD:
            begin
                if (fresh_reg[idx_reg])
                begin
                    sum_next   = sum_reg + SUM_W'(rd_spd);
                    f_next     = rd_ang;
                    q_next     = '0;
                    state_next = S_QUAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (last_idx)
                        state_next = S_VLOAD;
                end
            end
            S_QUAD:
            begin
                if (f_reg >= 16'(QUARTER))
                begin
                    f_next = f_reg - 16'(QUARTER);
                    q_next = q_reg + 1'b1;
                end
                else
                begin
                    cctrl.load = 1'b1;
                    iter_next  = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cctrl.step = 1'b1;
                iter_next  = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                sx_next    = sx_reg + ux;
                sy_next    = sy_reg + uy;
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? S_VLOAD : S_MLOAD;
            end
            S_VLOAD:
            begin
                if ((sx_reg == '0) && (sy_reg == '0))
                begin
                    res_angle_next = '0;
                    state_next     = S_DIVINIT;
                end
                else
                begin
                    cctrl.load = 1'b1;
                    cx_init    = xs;
                    cy_init    = ys;
                    cz_init    = '0;
                    if (sx_reg < 0)
                    begin
                        if (sy_reg >= 0)
                        begin
                            cx_init = ys;
                            cy_init = -xs;
                            cz_init = ZW'(QUARTER) <<< 16;
                        end
                        else
                        begin
                            cx_init = -ys;
                            cy_init = xs;
                            cz_init = -(ZW'(QUARTER) <<< 16);
                        end
                    end
                    iter_next  = '0;
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                cctrl.step     = 1'b1;
                cctrl.vec_mode = 1'b1;
                iter_next      = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    state_next = S_VEND;
            end
            S_VEND:
            begin
                if (cd < 0)
                    res_angle_next = 16'(cd + (ZW-16)'(TURN));
                else if (cd >= (ZW-16)'(TURN))
                    res_angle_next = 16'(cd - (ZW-16)'(TURN));
                else
                    res_angle_next = 16'(cd);
                state_next = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                sum_next   = sum_reg + SUM_W'(n_reg >> 1);
                rem_next   = '0;
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, n_reg})
                begin
                    rem_next = CNT_W'(rem_sh - {1'b0, n_reg});
                    sum_next = {sum_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[CNT_W-1:0];
                    sum_next = {sum_reg[SUM_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    res_status_next = STATUS_MEAN;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_angle_next  = res_angle_reg;
                    out_speed_next  = (res_status_reg == STATUS_MEAN) ? sum_reg[15:0]
                                      : res_speed_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_age_reg    <= 16'd5000;
            angle_lim_reg  <= 15'd3000;
            speed_lim_reg  <= 16'd800;
            slot_valid_reg <= '0;
            write_slot_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_age_reg    <= max_age_next;
            angle_lim_reg  <= angle_lim_next;
            speed_lim_reg  <= speed_lim_next;
            slot_valid_reg <= slot_valid_next;
            write_slot_reg <= write_slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_angle_reg[write_slot_reg] <= pn_reg[15:0];
            slot_speed_reg[write_slot_reg] <= pspeed_reg;
            slot_time_reg[write_slot_reg]  <= now_reg;
        end
        pn_reg         <= pn_next;
        pspeed_reg     <= pspeed_next;
        now_reg        <= now_next;
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        sel_reg        <= sel_next;
        best_reg       <= best_next;
        fresh_reg      <= fresh_next;
        n_reg          <= n_next;
        score_reg      <= score_next;
        best_score_reg <= best_score_next;
        a_ang_reg      <= a_ang_next;
        a_spd_reg      <= a_spd_next;
        sum_reg        <= sum_next;
        f_reg          <= f_next;
        q_reg          <= q_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        iter_reg       <= iter_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_angle_reg  <= res_angle_next;
        res_speed_reg  <= res_speed_next;
        out_status_reg <= out_status_next;
        out_angle_reg  <= out_angle_next;
        out_speed_reg  <= out_speed_next;
    end

    assign out_valid     = out_valid_reg;
    assign fusion_status = out_status_reg;
    assign fused_angle   = out_angle_reg;
    assign fused_speed   = out_speed_reg;

`ifndef SYNTHESIS
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (fusion_status == STATUS_NONE))
            |-> ((fused_angle == '0) && (fused_speed == '0)))
        else $error("no-data result carries nonzero payload");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fused_angle < 16'(TURN)))
        else $error("fused angle out of range");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= IDX_W'(SLOTS - 1))
        else $error("write pointer out of range");

    a_push_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !operation) |=> !$rose(out_valid))
        else $error("push produced a result item");
`endif

endmodule

@@ hw/rtl/wsmv_cordic.sv @@
module wsmv_cordic
    import wsmv_pkg::*;
(
    input  logic                 clk,
    input  cordic_ctrl_t         ctrl,
    input  logic signed [CW-1:0] x_init,
    input  logic signed [CW-1:0] y_init,
    input  logic signed [ZW-1:0] z_init,
    output logic signed [CW-1:0] x,
    output logic signed [CW-1:0] y,
    output logic signed [ZW-1:0] z
);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 pos;

    always_comb
    begin
        dx  = y_reg >>> ctrl.iter;
        dy  = x_reg >>> ctrl.iter;
        at  = atan_lut(ctrl.iter);
        pos = ctrl.vec_mode ? y_reg[CW-1] : !z_reg[ZW-1];
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        priority if (ctrl.load)
        begin
            x_next = x_init;
            y_next = y_init;
            z_next = z_init;
        end
        else if (ctrl.step)
        begin
            if (pos)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

endmodule
